### design/stt_pkg.sv
// Shared types, codes and sizes for the software timer slot table.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int SLOTS         = 64;
  localparam int TIME_BITS     = 32;
  localparam int SLOT_BITS     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_BITS      = SLOT_BITS + 1;
  localparam int ID_BITS       = 16;
  localparam int FIELD_BITS    = 32;
  localparam int RES_SLOT_BITS = 6;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_RUN   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FIRE   = 1'b1
  } kind_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [ID_BITS-1:0]    timer_id;
    logic [FIELD_BITS-1:0] time_value;
    logic [FIELD_BITS-1:0] period;
    logic                  periodic;
    logic [FIELD_BITS-1:0] now;
  } item_t;

  typedef struct packed {
    kind_e                    kind;
    status_e                  status;
    logic [ID_BITS-1:0]       fired_id;
    logic [RES_SLOT_BITS-1:0] slot;
    logic                     last;
  } result_t;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic [ID_BITS-1:0]   ident;
    logic [TIME_BITS-1:0] expiry;
    logic [TIME_BITS-1:0] period;
    logic                 reloads;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

### design/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/stt_seq.sv
// Command sequencer: slot valid bits, table scan and result generation.
`timescale 1ns / 1ps
module stt_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enabled_i,
  input  logic             start,
  input  stt_pkg::item_t   req_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output stt_pkg::result_t res_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FREE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  localparam logic [stt_pkg::SLOT_BITS-1:0] LastSlot =
    stt_pkg::SLOT_BITS'(stt_pkg::SLOTS - 1);
  localparam logic [stt_pkg::IDX_BITS-1:0] IdxEnd = stt_pkg::IDX_BITS'(stt_pkg::SLOTS);

  state_e                            state_q, state_d;
  logic [stt_pkg::IDX_BITS-1:0]      idx_q, idx_d;
  logic                              ev_q, ev_d;
  logic [stt_pkg::SLOT_BITS-1:0]     ev_idx_q, ev_idx_d;
  stt_pkg::item_t                    op_q, op_d;
  logic [stt_pkg::SLOTS-1:0]         valid_q, valid_d;
  logic                              pend_q, pend_d;
  logic [stt_pkg::ID_BITS-1:0]       pend_id_q, pend_id_d;
  logic [stt_pkg::SLOT_BITS-1:0]     pend_slot_q, pend_slot_d;

  logic                              mem_we, mem_re;
  logic [stt_pkg::SLOT_BITS-1:0]     mem_waddr, mem_raddr, free_idx;
  stt_pkg::entry_t                   mem_wdata, rd_entry;
  logic [stt_pkg::ENTRY_BITS-1:0]    mem_rdata;
  logic [stt_pkg::TIME_BITS-1:0]     now_t;
  logic                              hit_valid, fire, match;

  stt_ram #(
    .WIDTH(stt_pkg::ENTRY_BITS),
    .DEPTH(stt_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_entry  = stt_pkg::entry_t'(mem_rdata);
  assign now_t     = stt_pkg::TIME_BITS'(op_q.now);
  assign hit_valid = valid_q[ev_idx_q];
  assign fire      = hit_valid && (now_t >= rd_entry.expiry);
  assign match     = hit_valid && (rd_entry.ident == op_q.timer_id);
  assign free_idx  = idx_q[stt_pkg::SLOT_BITS-1:0];
  assign mem_raddr = idx_q[stt_pkg::SLOT_BITS-1:0];
  assign busy_o    = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ev_d        = 1'b0;
    ev_idx_d    = ev_idx_q;
    op_d        = op_q;
    valid_d     = valid_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    pend_slot_d = pend_slot_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ev_idx_q;
    mem_wdata   = rd_entry;
    res_valid_o = 1'b0;
    res_o       = '{kind: stt_pkg::KIND_STATUS, status: stt_pkg::ST_OK,
                    fired_id: op_q.timer_id, slot: '0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d   = req_i;
          idx_d  = '0;
          pend_d = 1'b0;
          if (!enabled_i) begin
            if (req_i.cmd != stt_pkg::CMD_TICK) begin
              res_valid_o     = 1'b1;
              res_o.status    = stt_pkg::ST_NOT_RUN;
              res_o.fired_id  = req_i.timer_id;
            end
          end else if (req_i.cmd == stt_pkg::CMD_ADD) begin
            state_d = S_FREE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_FREE: begin
        // Walk the valid bits for the lowest free slot
        if (!valid_q[free_idx]) begin
          mem_we            = 1'b1;
          mem_waddr         = free_idx;
          mem_wdata.ident   = op_q.timer_id;
          mem_wdata.expiry  = stt_pkg::TIME_BITS'(op_q.time_value);
          mem_wdata.period  = stt_pkg::TIME_BITS'(op_q.period);
          mem_wdata.reloads = op_q.periodic;
          valid_d[free_idx] = 1'b1;
          res_valid_o       = 1'b1;
          res_o.slot        = stt_pkg::RES_SLOT_BITS'(free_idx);
          state_d           = S_IDLE;
        end else if (free_idx == LastSlot) begin
          res_valid_o  = 1'b1;
          res_o.status = stt_pkg::ST_FULL;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous slot is evaluated
        mem_re = (idx_q < IdxEnd);
        if (mem_re) begin
          idx_d    = idx_q + 1'b1;
          ev_d     = 1'b1;
          ev_idx_d = mem_raddr;
        end
        if (ev_q) begin
          if (op_q.cmd == stt_pkg::CMD_TICK) begin
            if (fire) begin
              if (rd_entry.reloads) begin
                mem_we           = 1'b1;
                mem_wdata.expiry = rd_entry.expiry + rd_entry.period;
              end
              // Hold each fire until the next one so the final one can carry last
              if (pend_q) begin
                res_valid_o    = 1'b1;
                res_o.kind     = stt_pkg::KIND_FIRE;
                res_o.fired_id = pend_id_q;
                res_o.slot     = stt_pkg::RES_SLOT_BITS'(pend_slot_q);
                res_o.last     = 1'b0;
              end
              pend_d      = 1'b1;
              pend_id_d   = rd_entry.ident;
              pend_slot_d = ev_idx_q;
            end
            if (ev_idx_q == LastSlot) begin
              state_d = S_FLUSH;
            end
          end else if (match) begin
            if (op_q.cmd == stt_pkg::CMD_DELETE) begin
              valid_d[ev_idx_q] = 1'b0;
            end else begin
              mem_we           = 1'b1;
              mem_wdata.expiry = stt_pkg::TIME_BITS'(op_q.time_value) + now_t;
            end
            res_valid_o = 1'b1;
            res_o.slot  = stt_pkg::RES_SLOT_BITS'(ev_idx_q);
            state_d     = S_IDLE;
          end else if (ev_idx_q == LastSlot) begin
            res_valid_o  = 1'b1;
            res_o.status = stt_pkg::ST_NOT_FOUND;
            state_d      = S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (pend_q) begin
          res_valid_o    = 1'b1;
          res_o.kind     = stt_pkg::KIND_FIRE;
          res_o.fired_id = pend_id_q;
          res_o.slot     = stt_pkg::RES_SLOT_BITS'(pend_slot_q);
        end
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ev_q    <= 1'b0;
      valid_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ev_q    <= ev_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    ev_idx_q    <= ev_idx_d;
    op_q        <= op_d;
    pend_id_q   <= pend_id_d;
    pend_slot_q <= pend_slot_d;
  end

endmodule

### design/software_timer_slot_table.sv
// Top level of the software timer slot table: enable register and result register.
// Add: the walk runs from slot 0 to the lowest free slot, which the result reports.
// Delete and modify: the walk runs from slot 0 to the lowest matching slot.
// Tick: busy for the whole walk; each fire waits for the next one or the walk's end, so the final one carries last.
// Throughput: one item at a time; busy is high while the slot walk runs.
// Reset clears the enable and the valid bits at once; no clearing pass.
`timescale 1ns / 1ps
module software_timer_slot_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  stt_pkg::item_t   req_i,
  output logic             res_valid_o,
  output stt_pkg::result_t res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  logic             enabled_q;
  logic             seq_valid;
  stt_pkg::result_t seq_res;
  logic             res_valid_q;
  stt_pkg::result_t res_q;

  stt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enabled_i  (enabled_q),
    .start      (start),
    .req_i      (req_i),
    .busy_o     (busy),
    .res_valid_o(seq_valid),
    .res_o      (seq_res)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        enabled_q <= cfg_data_i;
      end
      res_valid_q <= seq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= seq_res;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### design/stt_checker.sv
// Port-level checks for the software timer slot table, bound to the top level.
`timescale 1ns / 1ps
module stt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             busy,
  input logic             res_valid_o,
  input stt_pkg::result_t res_o
);

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == stt_pkg::KIND_FIRE |-> res_o.status == stt_pkg::ST_OK)
    else $error("fire transaction with nonzero status");

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == stt_pkg::KIND_STATUS && res_o.status != stt_pkg::ST_OK
    |-> res_o.slot == '0)
    else $error("failed command reports a slot");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == stt_pkg::KIND_STATUS |-> res_o.last)
    else $error("status transaction without last");

  a_more_fires_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == stt_pkg::KIND_FIRE && !res_o.last |-> busy)
    else $error("idle while a tick still owes fires");

endmodule

bind software_timer_slot_table stt_checker u_stt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

### test/timer_table_checker.sv
// Checker for the timer slot table: tracks slot state, predicts each result and compares.
`timescale 1ns / 1ps
module timer_table_checker
  import stt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   req_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  logic    cfg_data_i,
  output int      fail_count_o,
  output int      outstanding_o
);

  localparam int MAX_FIRES = 64;

  logic                 run_enabled;
  logic                 live    [SLOTS];
  logic [ID_BITS-1:0]   ident   [SLOTS];
  logic [TIME_BITS-1:0] expiry  [SLOTS];
  logic [TIME_BITS-1:0] reload  [SLOTS];
  logic                 repeats [SLOTS];
  result_t              due_results[$];

  function automatic result_t status_result(input status_e st, input logic [ID_BITS-1:0] id,
                                            input int s);
    result_t r;
    r.kind     = KIND_STATUS;
    r.status   = st;
    r.fired_id = id;
    r.slot     = RES_SLOT_BITS'(s);
    r.last     = 1'b1;
    return r;
  endfunction

  // Work out the results of one transaction and advance the slot state.
  task automatic apply_timer_request(input item_t rq);
    int                   s;
    int                   hit;
    int                   last_due;
    int                   fires;
    logic [TIME_BITS-1:0] tick_now;
    result_t              r;
    tick_now = rq.now[TIME_BITS-1:0];
    if (rq.cmd == CMD_TICK) begin
      if (run_enabled) begin
        // Slots are independent, so the last firing slot is known up front.
        last_due = -1;
        for (s = 0; s < SLOTS; s++)
          if (live[s] && tick_now >= expiry[s]) last_due = s;
        fires = 0;
        for (s = 0; s < SLOTS && fires < MAX_FIRES; s++) begin
          if (live[s] && tick_now >= expiry[s]) begin
            r.kind     = KIND_FIRE;
            r.status   = ST_OK;
            r.fired_id = ident[s];
            r.slot     = RES_SLOT_BITS'(s);
            r.last     = (s == last_due) || (fires == MAX_FIRES - 1);
            due_results.push_back(r);
            fires++;
            if (repeats[s]) expiry[s] = expiry[s] + reload[s];
          end
        end
      end
    end else if (!run_enabled) begin
      due_results.push_back(status_result(ST_NOT_RUN, rq.timer_id, 0));
    end else if (rq.cmd == CMD_ADD) begin
      hit = -1;
      for (s = SLOTS - 1; s >= 0; s--)
        if (!live[s]) hit = s;
      if (hit < 0) begin
        due_results.push_back(status_result(ST_FULL, rq.timer_id, 0));
      end else begin
        live[hit]    = 1'b1;
        ident[hit]   = rq.timer_id;
        expiry[hit]  = rq.time_value[TIME_BITS-1:0];
        reload[hit]  = rq.period[TIME_BITS-1:0];
        repeats[hit] = rq.periodic;
        due_results.push_back(status_result(ST_OK, rq.timer_id, hit));
      end
    end else begin
      hit = -1;
      for (s = SLOTS - 1; s >= 0; s--)
        if (live[s] && ident[s] == rq.timer_id) hit = s;
      if (hit < 0) begin
        due_results.push_back(status_result(ST_NOT_FOUND, rq.timer_id, 0));
      end else begin
        if (rq.cmd == CMD_DELETE) live[hit] = 1'b0;
        else expiry[hit] = rq.time_value[TIME_BITS-1:0] + tick_now;
        due_results.push_back(status_result(ST_OK, rq.timer_id, hit));
      end
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      $error("result with nothing expected: kind %0d status %0d id %h slot %0d last %0d",
             got.kind, got.status, got.fired_id, got.slot, got.last);
      fail_count_o++;
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fail_count_o++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count_o++;
      end
      if (got.fired_id !== want.fired_id) begin
        $error("fired_id: expected %h, got %h", want.fired_id, got.fired_id);
        fail_count_o++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        fail_count_o++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count_o++;
      end
    end
  endtask

  initial fail_count_o = 0;

  // Compare before predicting: a new transaction's results queue behind older ones.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_enabled = 1'b0;
      for (int s = 0; s < SLOTS; s++) live[s] = 1'b0;
      due_results.delete();
    end else begin
      if (res_valid_i) check_result(res_i);
      if (cfg_valid_i && cfg_ready_i) run_enabled = cfg_data_i;
      if (start_i && !busy_i) apply_timer_request(req_i);
    end
    outstanding_o = due_results.size();
  end

endmodule

### test/software_timer_slot_table_tb.sv
// Testbench top for the timer slot table: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps
module software_timer_slot_table_tb;
  import stt_pkg::*;

  localparam int ITEM_TARGET   = 230;
  localparam int SETTLE_CYCLES = 70;
  localparam int DRAIN_LIMIT   = 20000;

  typedef enum int {MIX_NORMAL, MIX_FILL, MIX_DRAIN} mix_e;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   req_i;
  logic    res_valid_o;
  result_t res_o;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  logic    cfg_data_i;
  int      fail_count;
  int      outstanding;

  logic [ID_BITS-1:0]   id_pool [16];
  logic [TIME_BITS-1:0] cur_tick;
  logic                 run_on;
  int                   accepted_items;

  software_timer_slot_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  timer_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .res_valid_i   (res_valid_o),
    .res_i         (res_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic item_t make_req(input cmd_e c, input logic [15:0] id,
                                     input logic [31:0] tv, input logic [31:0] per,
                                     input logic rl, input logic [31:0] nw);
    item_t it;
    it.cmd        = c;
    it.timer_id   = id;
    it.time_value = tv;
    it.period     = per;
    it.periodic   = rl;
    it.now        = nw;
    return it;
  endfunction

  // Mostly pool identifiers so deletes and modifies find their timers.
  function automatic item_t random_request(input mix_e mix);
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (mix == MIX_FILL) it.cmd = CMD_ADD;
    else if (mix == MIX_DRAIN) it.cmd = (pick < 70) ? CMD_DELETE : CMD_TICK;
    else if (pick < 35) it.cmd = CMD_ADD;
    else if (pick < 55) it.cmd = CMD_DELETE;
    else if (pick < 72) it.cmd = CMD_MODIFY;
    else it.cmd = CMD_TICK;
    it.timer_id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(15)];
    it.periodic = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick == 0) it.period = $urandom;
    else if (pick == 1) it.period = '0;
    else it.period = $urandom_range(1, 200);
    pick = $urandom_range(9);
    if (it.cmd == CMD_TICK) begin
      if (pick == 0) cur_tick = $urandom;
      else if (pick == 1) cur_tick = 32'hFFFF_FFFF - $urandom_range(200);
      else cur_tick = cur_tick + $urandom_range(1, 60);
      it.now = cur_tick;
    end else begin
      it.now = (pick == 0) ? $urandom : cur_tick;
    end
    pick = $urandom_range(9);
    if (pick == 0) it.time_value = $urandom;
    else if (it.cmd == CMD_MODIFY) it.time_value = $urandom_range(300);
    else it.time_value = cur_tick + $urandom_range(300);
    return it;
  endfunction

  function automatic int next_gap(input bit quiet);
    int unsigned pick;
    pick = $urandom_range(99);
    if (quiet || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold start until busy is seen low, then idle for a random gap.
  task automatic send(input item_t it, input bit quiet);
    int g;
    req_i <= it;
    start <= 1'b1;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (it.cmd != CMD_TICK || run_on) accepted_items++;
    g = next_gap(quiet);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Drop start and wait for every expected result and for the slot walk to end.
  task automatic settle();
    int n;
    start <= 1'b0;
    n = 0;
    do begin
      @(negedge clk_i);
      n++;
    end while ((outstanding != 0 || busy) && n < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic on);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    run_on = on;
  endtask

  initial begin
    int   round;
    int   k;
    int   n;
    bit   quiet;
    logic on;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b0;
    run_on         = 1'b0;
    cur_tick       = '0;
    accepted_items = 0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (k = 2; k < 16; k++) id_pool[k] = 16'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Not running: commands rejected, tick ignored.
    write_enable(1'b0);
    send(make_req(CMD_ADD, 16'h1234, 32'd10, 32'd5, 1'b1, 32'd0), 1'b0);
    send(make_req(CMD_DELETE, 16'h1234, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_MODIFY, 16'h1234, 32'd3, 32'd0, 1'b0, 32'd1), 1'b0);
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF), 1'b0);
    settle();

    write_enable(1'b1);
    // Empty table, unknown identifiers.
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_DELETE, 16'hFFFF, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_MODIFY, 16'h0000, 32'd7, 32'd0, 1'b0, 32'd0), 1'b0);
    // Zero period, extreme expiry and period, duplicate identifier, wrapping reload.
    send(make_req(CMD_ADD, 16'h0000, 32'd0, 32'd0, 1'b1, 32'd0), 1'b0);
    send(make_req(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_ADD, 16'h0000, 32'd5, 32'd7, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_ADD, 16'hA5A5, 32'hFFFF_FFF0, 32'h20, 1'b1, 32'd0), 1'b0);
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd4), 1'b0);
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF), 1'b0);
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'h10), 1'b0);
    // Modify with a wrapping sum, then delete both duplicates and miss once.
    send(make_req(CMD_MODIFY, 16'h0000, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd2), 1'b0);
    send(make_req(CMD_DELETE, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_DELETE, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_DELETE, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_ADD, 16'h5A5A, 32'd0, 32'd1, 1'b1, 32'd0), 1'b0);
    send(make_req(CMD_MODIFY, 16'hFFFF, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);
    send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'd0), 1'b0);

    round = 0;
    while (accepted_items < ITEM_TARGET) begin
      settle();
      if (round == 1) on = 1'b1;
      else if (round == 3) on = 1'b0;
      else on = ($urandom_range(4) != 0);
      write_enable(on);
      quiet = ($urandom_range(3) == 0);
      if (round == 1) begin
        // Overfill the table, fire every slot at once, then clear much of it.
        for (k = 0; k < SLOTS + 2; k++) send(random_request(MIX_FILL), quiet);
        send(make_req(CMD_TICK, 16'h0000, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF), quiet);
        for (k = 0; k < 30; k++) send(random_request(MIX_DRAIN), quiet);
      end else begin
        n = $urandom_range(15, 30);
        for (k = 0; k < n; k++) send(random_request(MIX_NORMAL), quiet);
      end
      round++;
    end

    settle();
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
